/* rtl/idtp_pkg.sv */
`default_nettype none
package idtp_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned ID_W            = 32;
    localparam int unsigned TAG_W           = 64;

    // request codes
    localparam logic REQ_NOTE  = 1'b0;
    localparam logic REQ_KNOWN = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

endpackage
`default_nettype wire

/* rtl/idtp_if.sv */
`default_nettype none
interface idtp_req_if;
    import idtp_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [ID_W-1:0]  item_id;
    logic [TAG_W-1:0] owner_tag;

    modport source (output valid, output req_type, output item_id, output owner_tag,
                    input ready);
    modport sink   (input valid, input req_type, input item_id, input owner_tag,
                    output ready);
endinterface

interface idtp_rsp_if;
    logic valid;
    logic ready;
    logic answer;

    modport source (output valid, output answer, input ready);
    modport sink   (input valid, input answer, output ready);
endinterface
`default_nettype wire

/* rtl/id_tag_pair_table.sv */
// Scan: after a request is accepted the filled entries are read in order, F being the fill
//   count (up to TABLE_DEPTH), and the response step then raises the result. An empty
//   table goes straight to the response step; a hit on an entry ends the scan early.
// Requests: a new one is taken only once the last result is raised; ready returns in
//   the same cycle as the result. The single RAM read port and the shared id/tag
//   comparator visit one entry per cycle. A result still waiting in the output
//   register holds the next one in the response step, and input stays stalled.
// Reset: synchronous, active low; the table reads as empty (fill count zero), no
//   clearing pass is needed. A pending result is dropped.
`default_nettype none
module id_tag_pair_table #(
    parameter int unsigned TABLE_DEPTH = idtp_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    idtp_req_if.sink   i_req,
    idtp_rsp_if.source o_rsp
);
    import idtp_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    // control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;       // number of valid entries
    logic [CW-1:0]     r_rd_idx, n_rd_idx;   // next entry to read
    logic              r_dv, n_dv;           // RAM read data valid this cycle
    logic              r_out_valid, n_out_valid;

    // payload
    logic              r_req_type;
    logic [ID_W-1:0]   r_id;
    logic [TAG_W-1:0]  r_tag;
    logic [AW-1:0]     r_cmp_idx;            // entry whose data is on the RAM output
    logic              r_ans, n_ans;
    logic              r_answer;

    t_entry            w_rd_data;
    logic              w_id_eq, w_tag_eq, w_hit, w_end, w_issue;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic              w_req_acc, w_out_take;

    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_out_take = r_out_valid && o_rsp.ready;

    // Shared comparator: one entry per cycle against the held request.
    assign w_id_eq  = r_dv && (w_rd_data.id == r_id);
    assign w_tag_eq = (w_rd_data.tag == r_tag);
    assign w_hit    = (r_state == S_SCAN) &&
                      ((r_req_type == REQ_NOTE) ? w_id_eq : (w_id_eq && w_tag_eq));
    // Scan exhausted: nothing in flight and no entry left to read.
    assign w_end    = (r_state == S_SCAN) && !r_dv && (r_rd_idx >= r_fill);
    assign w_issue  = (r_state == S_SCAN) && !w_hit && (r_rd_idx < r_fill);

    // Note request writes: retag on an id hit with a new tag, append on a miss
    // while there is room. Known requests never write.
    assign w_wr_en   = (r_req_type == REQ_NOTE) &&
                       ((w_hit && !w_tag_eq) || (w_end && (r_fill != FULL)));
    assign w_wr_addr = w_hit ? r_cmp_idx : r_fill[AW-1:0];

    idtp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data ({r_id, r_tag}),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_dv        = 1'b0;
        n_ans       = r_ans;
        n_out_valid = r_out_valid && !w_out_take;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_state  = S_SCAN;
                    n_rd_idx = '0;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    // note: answer 1 only when the tag was replaced
                    n_ans   = (r_req_type == REQ_NOTE) ? !w_tag_eq : 1'b1;
                    n_state = S_RESP;
                end else if (w_end) begin
                    if ((r_req_type == REQ_NOTE) && (r_fill != FULL)) begin
                        n_fill = r_fill + CW'(1);
                        n_ans  = 1'b1;
                    end else begin
                        n_ans  = 1'b0;
                    end
                    n_state = S_RESP;
                end else begin
                    n_dv = w_issue;
                    if (w_issue) begin
                        n_rd_idx = r_rd_idx + CW'(1);
                    end
                end
            end
            S_RESP: begin
                // hold the result until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ans <= n_ans;
        if (w_req_acc) begin
            r_req_type <= i_req.req_type;
            r_id       <= i_req.item_id;
            r_tag      <= i_req.owner_tag;
        end
        if (w_issue) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
        if ((r_state == S_RESP) && (!r_out_valid || o_rsp.ready)) begin
            r_answer <= r_ans;
        end
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.answer = r_answer;

    // fill count never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count beyond table depth");

    // fill count grows by at most one entry per request
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + CW'(1)))
        else $error("fill count jumped");

    // table is only written during a scan
    a_wr_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_SCAN))
        else $error("table write outside scan");

    // accepted request always starts a scan
    a_acc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> (r_state == S_SCAN))
        else $error("request accepted without scan");

    // a new result appears only out of the response step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_RESP))
        else $error("result raised outside response step");

endmodule
`default_nettype wire

/* rtl/idtp_ram.sv */
`default_nettype none
module idtp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

/* dv/idtp_answer_check.sv */
module idtp_answer_check #(
    parameter int unsigned TABLE_DEPTH = idtp_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    idtp_req_if       req_mon,
    idtp_rsp_if       rsp_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output int        o_retags,
    output int        o_full_drops,
    output int        o_known_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import idtp_pkg::*;

    typedef struct {
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
        logic             answer;
    } t_due;

    // shadow copy of the pair table
    logic [ID_W-1:0]  pair_ids  [TABLE_DEPTH];
    logic [TAG_W-1:0] pair_tags [TABLE_DEPTH];
    int unsigned      pair_fill;

    t_due answers_due[$];
    t_due oldest;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Applies one request to the shadow table and returns its answer.
    function automatic logic pair_table_answer(input logic kind, input logic [ID_W-1:0] id,
                                               input logic [TAG_W-1:0] tag);
        if (kind == REQ_KNOWN) begin
            for (int i = 0; i < pair_fill; i++) begin
                if (pair_ids[i] == id && pair_tags[i] == tag) begin
                    o_known_hits++;
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        // note: first entry with the id wins
        for (int i = 0; i < pair_fill; i++) begin
            if (pair_ids[i] == id) begin
                if (pair_tags[i] == tag)
                    return 1'b0;
                pair_tags[i] = tag;
                o_retags++;
                return 1'b1;
            end
        end
        if (pair_fill >= TABLE_DEPTH) begin
            o_full_drops++;
            return 1'b0;
        end
        pair_ids[pair_fill]  = id;
        pair_tags[pair_fill] = tag;
        pair_fill++;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair_fill = 0;
            answers_due.delete();
        end else begin
            // answers first: one taken on this edge belongs to an older request
            if (rsp_mon.valid && rsp_mon.ready) begin
                o_checked++;
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("answer %0b with no request outstanding",
                                              rsp_mon.answer));
                end else begin
                    oldest = answers_due.pop_front();
                    if (rsp_mon.answer !== oldest.answer)
                        report_mismatch($sformatf(
                            "%s id %08h tag %016h: answer %0b, predicted %0b",
                            (oldest.kind == REQ_NOTE) ? "note" : "known", oldest.id,
                            oldest.tag, rsp_mon.answer, oldest.answer));
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                oldest.kind   = req_mon.req_type;
                oldest.id     = req_mon.item_id;
                oldest.tag    = req_mon.owner_tag;
                oldest.answer = pair_table_answer(req_mon.req_type, req_mon.item_id,
                                                  req_mon.owner_tag);
                answers_due.push_back(oldest);
            end
        end
        o_pending = answers_due.size();
    end

endmodule

/* dv/tb_id_tag_pair_table.sv */
module tb_id_tag_pair_table;
    timeunit 1ns;
    timeprecision 1ps;
    import idtp_pkg::*;

    // A scan reads at most the whole table, so a full table bounds the latency.
    localparam int DRAIN_CYCLES   = 3 + TABLE_DEPTH_DEF + 8;
    localparam int RANDOM_ITEMS   = 1075;
    localparam int HOLD_AFTER     = 300;   // requests accepted before the long hold-off
    localparam int HOLD_CYCLES    = 300;
    localparam int PAUSE_AT       = 600;   // random request index of the drain pause
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ID_POOL        = 24;
    localparam int TAG_POOL       = 4;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    idtp_req_if req_ch ();
    idtp_rsp_if rsp_ch ();

    id_tag_pair_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    int chk_fails, chk_pending, chk_checked, chk_retags, chk_drops, chk_known_hits;

    idtp_answer_check u_answer_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked),
        .o_retags     (chk_retags),
        .o_full_drops (chk_drops),
        .o_known_hits (chk_known_hits)
    );

    // Stimulus bookkeeping; sent_count is shared with the response side.
    int  sent_count  = 0;
    int  note_count  = 0;
    int  known_count = 0;
    bit  burst_mode  = 1'b0;

    // Ids 0..15 of the pool end up in the table during the directed part; the
    // rest arrive once it is full and are dropped. A small tag pool keeps
    // matches and retags frequent.
    logic [ID_W-1:0]  id_pool  [ID_POOL];
    logic [TAG_W-1:0] tag_pool [TAG_POOL];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len(input bit no_idle);
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    function automatic t_request make_req(input logic kind, input logic [ID_W-1:0] id,
                                          input logic [TAG_W-1:0] tag);
        t_request r;
        r.kind = kind;
        r.id   = id;
        r.tag  = tag;
        return r;
    endfunction

    // Offer one request from a falling edge and hold it until accepted.
    // valid is lowered only when a gap is taken, so it never gets two
    // assignments in one step.
    task automatic offer(input t_request r);
        int gap;
        gap = idle_len(burst_mode);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= r.kind;
        req_ch.item_id   <= r.id;
        req_ch.owner_tag <= r.tag;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
        if (r.kind == REQ_NOTE)
            note_count++;
        else
            known_count++;
        @(negedge i_clk);
    endtask

    // Request side: reset, directed sequence, random traffic, drain, verdict.
    initial begin
        t_request r;
        int       pick;

        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_NOTE;
        req_ch.item_id   <= '0;
        req_ch.owner_tag <= '0;
        i_rst_n          <= 1'b0;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL; i++)
            id_pool[i] = $urandom;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = {$urandom, $urandom};
        tag_pool[3] = {$urandom, $urandom};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // -- directed part --
        offer(make_req(REQ_KNOWN, '0, '0));         // query on an empty table
        offer(make_req(REQ_NOTE,  '0, '0));         // first append
        offer(make_req(REQ_NOTE,  '0, '0));         // same pair again: no change
        offer(make_req(REQ_NOTE,  '0, '1));         // same id, new tag: retag
        offer(make_req(REQ_KNOWN, '0, '1));         // hit after retag
        offer(make_req(REQ_NOTE,  '1, '0));         // second entry, extreme id
        offer(make_req(REQ_KNOWN, '1, '1));         // id present, tag differs
        offer(make_req(REQ_KNOWN, 32'h1234, '0));   // id absent
        offer(make_req(REQ_NOTE,  '1, '0));         // existing pair further down
        offer(make_req(REQ_KNOWN, '1, '0));         // hit on a later entry
        // fill the remaining fourteen slots, the last one included
        for (int i = 2; i < 16; i++)
            offer(make_req(REQ_NOTE, id_pool[i], tag_pool[i % TAG_POOL]));
        offer(make_req(REQ_NOTE, id_pool[16], tag_pool[2]));   // new id, table full

        // -- random part --
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                burst_mode = ($urandom_range(3) == 0);
            if (n == PAUSE_AT) begin
                // let every outstanding answer come back before going on
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (chk_pending != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 12)
                // noise: any type, any id, any tag
                r = make_req(1'($urandom_range(1)), $urandom, {$urandom, $urandom});
            else
                r = make_req(($urandom_range(99) < 55) ? REQ_NOTE : REQ_KNOWN,
                             id_pool[$urandom_range(ID_POOL - 1)],
                             tag_pool[$urandom_range(TAG_POOL - 1)]);
            offer(r);
        end

        req_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests (%0d note, %0d known), %0d answers compared.",
                 sent_count, note_count, known_count, chk_checked);
        $display("Table filled to capacity; %0d retags, %0d drops when full, %0d known hits.",
                 chk_retags, chk_drops, chk_known_hits);
        if (chk_fails == 0 && chk_pending == 0)
            $display("PASS id_tag_pair_table");
        else
            $display("FAIL id_tag_pair_table");
        $finish;
    end

    // Response side: alternating ready runs and stalls, with calm stretches,
    // plus one long hold-off so the block backs up and stops taking requests.
    initial begin
        int run_left;
        int cyc;
        bit level;
        bit calm;
        bit held;

        rsp_ch.ready <= 1'b0;
        run_left = 0;
        cyc      = 0;
        level    = 1'b0;
        calm     = 1'b0;
        held     = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 400 == 0)
                calm = ($urandom_range(2) == 0);
            if (!held && sent_count >= HOLD_AFTER) begin
                held     = 1'b1;
                level    = 1'b0;
                run_left = HOLD_CYCLES;
            end else if (run_left > 0) begin
                run_left--;
            end else if (level) begin
                run_left = idle_len(calm);
                if (run_left > 0) begin
                    level = 1'b0;
                    run_left--;
                end else begin
                    run_left = $urandom_range(1, 24);
                end
            end else begin
                level    = 1'b1;
                run_left = $urandom_range(1, 24);
            end
            rsp_ch.ready <= level;
        end
    end

    // Watchdog: too long without a handshake on either channel ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a handshake, %0d answers outstanding",
                 quiet, chk_pending);
        $display("FAIL id_tag_pair_table");
        $finish;
    end

endmodule
